/* hdl/grouped_score_aggregator_top_macros.svh */
// ----------------------------------------------------------------------------
// grouped score aggregator assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GROUPED_SCORE_AGGREGATOR_TOP_MACROS_SVH
`define GROUPED_SCORE_AGGREGATOR_TOP_MACROS_SVH

// condition holds in the same cycle
`define GSA_ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// condition holds in the following cycle
`define GSA_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* hdl/gsa_pkg.sv */
// ----------------------------------------------------------------------------
// gsa_pkg
// Widths, codes and shared types of the grouped score aggregator.
// ----------------------------------------------------------------------------
package gsa_pkg;

    localparam int COUNT_WIDTH   = 16;
    localparam int FRACTION_BITS = 16;
    localparam int SCORE_W       = 32;
    localparam int SUM_W         = 48;
    localparam int SHOWN_COUNT_W = 16;
    localparam int MODE_W        = 3;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int DIV_CNT_W     = $clog2(SUM_W);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [SHOWN_COUNT_W-1:0] SHOWN_CAP =
        (COUNT_WIDTH >= SHOWN_COUNT_W) ? {SHOWN_COUNT_W{1'b1}}
                                       : SHOWN_COUNT_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    typedef logic [MODE_W-1:0] mode_t;

    // aggregation modes
    localparam mode_t MODE_PARENT = 3'd0;
    localparam mode_t MODE_MIN    = 3'd1;
    localparam mode_t MODE_MAX    = 3'd2;
    localparam mode_t MODE_COUNT  = 3'd3;
    localparam mode_t MODE_AVG    = 3'd4;
    localparam mode_t MODE_SUM    = 3'd5;

    typedef logic [1:0] op_t;

    // item classes
    localparam op_t OP_SKIP     = 2'd0;
    localparam op_t OP_ACC      = 2'd1;
    localparam op_t OP_ACC_LAST = 2'd2;
    localparam op_t OP_LAST     = 2'd3;

    typedef struct packed {
        op_t                       op;
        logic signed [SCORE_W-1:0] parent;
        logic signed [SCORE_W-1:0] child;
    } q_entry_t;

    typedef struct packed {
        logic                   start;
        logic                   negate;
        logic [SUM_W-1:0]       dividend;
        logic [COUNT_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* hdl/gsa_ifs.sv */
// ----------------------------------------------------------------------------
// gsa channel interfaces
// Valid/ready channels for input items, result items and the mode register.
// ----------------------------------------------------------------------------
interface gsa_item_if;
    import gsa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] parent_score;
    logic signed [SCORE_W-1:0] child_score;
    logic                      has_child;
    logic                      last;

    modport source (output valid, parent_score, child_score, has_child, last,
                    input ready);
    modport sink   (input valid, parent_score, child_score, has_child, last,
                    output ready);
endinterface

interface gsa_result_if;
    import gsa_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SUM_W-1:0]       aggregate_score;
    logic [SHOWN_COUNT_W-1:0]      child_count;
    logic                          empty_min_max;
    logic                          count_overflow;

    modport source (output valid, aggregate_score, child_count, empty_min_max,
                    count_overflow, input ready);
    modport sink   (input valid, aggregate_score, child_count, empty_min_max,
                    count_overflow, output ready);
endinterface

interface gsa_cfg_if;
    import gsa_pkg::*;

    logic        valid;
    logic        ready;
    mode_t       data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* hdl/gsa_front.sv */
// ----------------------------------------------------------------------------
// gsa_front
// Accepts input items, classifies them and queues the ones with work to do.
// ----------------------------------------------------------------------------
module gsa_front
(
    input  logic              clk,
    input  logic              rst_n,
    gsa_item_if.sink          item_in,
    output logic              head_valid,
    output gsa_pkg::q_entry_t head,
    input  logic              pop
);
    import gsa_pkg::*;

    q_entry_t          q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   fill_reg;
    logic [QPTR_W:0]   fill_next;
    op_t               op;
    logic              take;
    logic              push;
    logic              do_pop;

    // classify the item
    always_comb
    begin
        if (item_in.has_child)
            op = item_in.last ? OP_ACC_LAST : OP_ACC;
        else
            op = item_in.last ? OP_LAST : OP_SKIP;
    end

    assign item_in.ready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign take          = item_in.valid && item_in.ready;
    // an item with no child that does not end a group leaves nothing to do
    assign push          = take && (op != OP_SKIP);
    assign head_valid    = (fill_reg != '0);
    assign do_pop        = pop && head_valid;
    assign head          = q_mem[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (!push && do_pop)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg].op     <= op;
            q_mem[wr_ptr_reg].parent <= item_in.parent_score;
            q_mem[wr_ptr_reg].child  <= item_in.child_score;
        end
    end

endmodule

/* hdl/gsa_div.sv */
// ----------------------------------------------------------------------------
// gsa_div
// Restoring divider, one quotient bit per cycle, for the group average.
// ----------------------------------------------------------------------------
module gsa_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  gsa_pkg::div_req_t req,
    output gsa_pkg::div_rsp_t rsp
);
    import gsa_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic                   neg_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]       num_reg;
    logic [COUNT_WIDTH-1:0] den_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [COUNT_WIDTH:0]   shifted;
    logic [COUNT_WIDTH:0]   diff;
    logic                   q_bit;

    // one restoring step
    always_comb
    begin
        shifted = {rem_reg, num_reg[SUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        q_bit   = !diff[COUNT_WIDTH];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(SUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, quotient shifts into the dividend register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            den_reg <= req.divisor;
            neg_reg <= req.negate;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[SUM_W-2:0], q_bit};
            rem_reg <= q_bit ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(num_reg) : $signed(num_reg);

endmodule

/* hdl/gsa_back.sv */
// ----------------------------------------------------------------------------
// gsa_back
// Keeps the running group state, forms the aggregate and holds the result.
// ----------------------------------------------------------------------------
module gsa_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  gsa_pkg::mode_t    mode,
    input  logic              head_valid,
    input  gsa_pkg::q_entry_t head,
    output logic              pop,
    output gsa_pkg::div_req_t div_req,
    input  gsa_pkg::div_rsp_t div_rsp,
    gsa_result_if.source      result_out
);
    import gsa_pkg::*;

    localparam logic [1:0] S_RUN = 2'd0;
    localparam logic [1:0] S_FIN = 2'd1;
    localparam logic [1:0] S_DIV = 2'd2;

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic signed [SCORE_W-1:0] min_reg;
    logic signed [SCORE_W-1:0] max_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [COUNT_WIDTH-1:0]    count_reg;
    logic                      ovf_reg;
    logic signed [SCORE_W-1:0] parent_reg;

    logic                      out_valid_reg;
    logic signed [SUM_W-1:0]   out_agg_reg;
    logic [SHOWN_COUNT_W-1:0]  out_count_reg;
    logic                      out_empty_reg;
    logic                      out_ovf_reg;

    logic                      accumulate;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic                      slot_free;
    logic                      write_result;
    logic                      clear_group;
    logic signed [SUM_W-1:0]   fin_agg;
    logic                      fin_empty;
    logic [63:0]               count_shift;
    logic [31:0]               count_ext;
    logic [SHOWN_COUNT_W-1:0]  shown_count;

    assign slot_free  = !out_valid_reg || result_out.ready;
    assign pop        = (state_reg == S_RUN);
    assign accumulate = pop && head_valid && (head.op == OP_ACC || head.op == OP_ACC_LAST);

    // saturating sum of the next child
    always_comb
    begin
        sum_wide = {sum_reg[SUM_W-1], sum_reg} + (SUM_W+1)'(head.child);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        else
            sum_sat = sum_wide[SUM_W-1:0];
    end

    // aggregate for every mode but a non-empty average
    always_comb
    begin
        fin_agg     = SUM_W'(parent_reg);
        fin_empty   = 1'b0;
        count_shift = 64'(count_reg) << FRACTION_BITS;
        case (mode)
            MODE_MIN, MODE_MAX:
            begin
                if (count_reg == '0)
                begin
                    fin_agg   = '0;
                    fin_empty = 1'b1;
                end
                else
                    fin_agg = (mode == MODE_MIN) ? SUM_W'(min_reg) : SUM_W'(max_reg);
            end
            MODE_COUNT:
            begin
                if (count_shift > 64'(SUM_MAX))
                    fin_agg = SUM_MAX;
                else
                    fin_agg = count_shift[SUM_W-1:0];
            end
            MODE_AVG:
                fin_agg = '0;
            MODE_SUM:
                fin_agg = sum_reg;
            default:
                fin_agg = SUM_W'(parent_reg);
        endcase
    end

    // shown count is capped at the output width
    always_comb
    begin
        count_ext   = 32'(count_reg);
        shown_count = (count_ext > 32'(SHOWN_CAP)) ? SHOWN_CAP
                                                   : count_ext[SHOWN_COUNT_W-1:0];
    end

    // divider request
    always_comb
    begin
        div_req.start    = (state_reg == S_FIN) && slot_free && (mode == MODE_AVG)
                           && (count_reg != '0);
        div_req.negate   = sum_reg[SUM_W-1];
        div_req.dividend = sum_reg[SUM_W-1] ? 48'(-sum_reg) : 48'(sum_reg);
        div_req.divisor  = count_reg;
    end

    assign write_result = ((state_reg == S_FIN) && slot_free && !div_req.start)
                          || ((state_reg == S_DIV) && div_rsp.done);
    assign clear_group  = write_result;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_RUN:
                if (head_valid && (head.op == OP_ACC_LAST || head.op == OP_LAST))
                    state_next = S_FIN;
            S_FIN:
                if (div_req.start)
                    state_next = S_DIV;
                else if (write_result)
                    state_next = S_RUN;
            S_DIV:
                if (div_rsp.done)
                    state_next = S_RUN;
            default:
                state_next = S_RUN;
        endcase
    end

    // group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            min_reg   <= SCORE_MAX;
            max_reg   <= SCORE_MIN;
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear_group)
            begin
                min_reg   <= SCORE_MAX;
                max_reg   <= SCORE_MIN;
                sum_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (accumulate)
            begin
                if (head.child < min_reg)
                    min_reg <= head.child;
                if (head.child > max_reg)
                    max_reg <= head.child;
                sum_reg <= sum_sat;
                if (count_reg == COUNT_MAX)
                    ovf_reg <= 1'b1;
                else
                    count_reg <= count_reg + 1'b1;
            end
        end
    end

    // parent score of the closing item
    always_ff @(posedge clk)
    begin
        if (pop && head_valid && (head.op == OP_ACC_LAST || head.op == OP_LAST))
            parent_reg <= head.parent;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (write_result)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (write_result)
        begin
            out_agg_reg   <= (state_reg == S_DIV) ? div_rsp.quotient : fin_agg;
            out_count_reg <= shown_count;
            out_empty_reg <= (state_reg == S_DIV) ? 1'b0 : fin_empty;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.aggregate_score = out_agg_reg;
    assign result_out.child_count     = out_count_reg;
    assign result_out.empty_min_max   = out_empty_reg;
    assign result_out.count_overflow  = out_ovf_reg;

endmodule

/* hdl/grouped_score_aggregator_top.sv */
// ----------------------------------------------------------------------------
// grouped_score_aggregator_top
// Streams child scores of a group and gives one aggregate per group.
// ----------------------------------------------------------------------------
// Items are taken at one per cycle while the four-entry queue has room; an
// item with a child accumulates as it leaves the queue, and an item with
// neither a child nor the last bit is dropped at the input. The item that ends
// a group passes through the back end states S_RUN (accumulate) and S_FIN (form
// the result), and in average mode with a non-empty group the bit-serial
// divider then runs, one quotient bit per cycle. A finished result waits in an
// output register while the next group keeps accumulating. The mode register is
// written through the cfg channel, which is always ready; it resets to
// parent score mode, and modes 6 and 7 also give the parent score.
`include "grouped_score_aggregator_top_macros.svh"

module grouped_score_aggregator_top
(
    input  logic         clk,
    input  logic         rst_n,
    gsa_item_if.sink     item_in,
    gsa_result_if.source result_out,
    gsa_cfg_if.sink      cfg
);
    import gsa_pkg::*;

    mode_t    mode_reg;
    logic     head_valid;
    q_entry_t head;
    logic     pop;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // mode register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_PARENT;
        else if (cfg.valid && cfg.ready)
            mode_reg <= cfg.data;
    end

    gsa_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    gsa_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .result_out (result_out)
    );

    gsa_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // an empty min or max result carries a zero score and a zero count
    `GSA_ASSERT_SAME(a_empty_is_zero, result_out.valid && result_out.empty_min_max, result_out.child_count == '0 && result_out.aggregate_score == '0, "empty group result not zero")

    // a saturated count shows as the cap
    `GSA_ASSERT_SAME(a_ovf_cap, result_out.valid && result_out.count_overflow, result_out.child_count == SHOWN_CAP, "overflow without capped count")

    // the divider starts only when the output slot will be free
    `GSA_ASSERT_SAME(a_div_slot, div_req.start, !result_out.valid || result_out.ready, "division started over a pending result")

    // a division never starts in the cycle after another start
    `GSA_ASSERT_NEXT(a_div_single, div_req.start, !div_req.start && !div_rsp.done, "divider restarted while busy")

endmodule

/* sim/gsa_aggregate_monitor.sv */
// ----------------------------------------------------------------------------
// gsa_aggregate_monitor
// Watches the item, result and mode channels of the grouped score
// aggregator, folds every accepted item into its own copy of the group
// state, and compares each result with the oldest aggregate still due.
// ----------------------------------------------------------------------------
module gsa_aggregate_monitor
(
    input  logic   clk,
    input  logic   rst_n,
    gsa_item_if    item,
    gsa_result_if  result,
    gsa_cfg_if     cfg,
    output int     mismatches,
    output int     outstanding
);
    import gsa_pkg::*;

    typedef struct {
        logic signed [SUM_W-1:0]  score;
        logic [SHOWN_COUNT_W-1:0] count;
        logic                     empty;
        logic                     saturated;
    } aggregate_t;

    // aggregates predicted but not yet seen on the result channel
    aggregate_t aggregates_due[$];

    // predicted group state
    mode_t                     agg_mode;
    logic signed [SCORE_W-1:0] grp_min;
    logic signed [SCORE_W-1:0] grp_max;
    logic signed [SUM_W-1:0]   grp_sum;
    logic [COUNT_WIDTH-1:0]    grp_count;
    logic                      grp_ovf;

    task automatic clear_group();
        grp_min   = SCORE_MAX;
        grp_max   = SCORE_MIN;
        grp_sum   = '0;
        grp_count = '0;
        grp_ovf   = 1'b0;
    endtask

    // fold one item into the group; a last item queues the aggregate
    task automatic fold_item(input logic signed [SCORE_W-1:0] parent,
                             input logic signed [SCORE_W-1:0] child,
                             input logic has_child, input logic last);
        longint     total;
        aggregate_t agg;
        if (has_child)
        begin
            if (child < grp_min)
                grp_min = child;
            if (child > grp_max)
                grp_max = child;
            total = longint'(grp_sum) + longint'(child);
            if (total > longint'(SUM_MAX))
                total = longint'(SUM_MAX);
            else if (total < longint'(SUM_MIN))
                total = longint'(SUM_MIN);
            grp_sum = SUM_W'(total);
            if (grp_count == COUNT_MAX)
                grp_ovf = 1'b1;
            else
                grp_count = grp_count + 1'b1;
        end
        if (last)
        begin
            agg.score = '0;
            agg.empty = 1'b0;
            case (agg_mode)
                MODE_MIN, MODE_MAX:
                begin
                    if (grp_count == '0)
                        agg.empty = 1'b1;
                    else if (agg_mode == MODE_MIN)
                        agg.score = grp_min;
                    else
                        agg.score = grp_max;
                end
                MODE_COUNT:
                begin
                    total = longint'(grp_count) << FRACTION_BITS;
                    if (total > longint'(SUM_MAX))
                        total = longint'(SUM_MAX);
                    agg.score = SUM_W'(total);
                end
                MODE_AVG:
                begin
                    // signed division truncates toward zero
                    if (grp_count != '0)
                        agg.score = SUM_W'(longint'(grp_sum) / longint'(grp_count));
                end
                MODE_SUM:
                    agg.score = grp_sum;
                default:
                    agg.score = parent;
            endcase
            agg.count = (longint'(grp_count) > longint'(SHOWN_CAP))
                        ? SHOWN_CAP : SHOWN_COUNT_W'(grp_count);
            agg.saturated = grp_ovf;
            aggregates_due.push_back(agg);
            clear_group();
        end
    endtask

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // track the mode register, predict items, check results
    always @(posedge clk or negedge rst_n)
    begin
        aggregate_t due;
        if (!rst_n)
        begin
            agg_mode = MODE_PARENT;
            clear_group();
            aggregates_due.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                agg_mode = cfg.data;
            if (item.valid && item.ready)
                fold_item(item.parent_score, item.child_score, item.has_child, item.last);
            if (result.valid && result.ready)
            begin
                if (aggregates_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no aggregate due, expected none, got %0d",
                             $time, result.aggregate_score);
                end
                else
                begin
                    due = aggregates_due.pop_front();
                    check_field("aggregate_score", due.score, result.aggregate_score);
                    check_field("child_count", due.count, result.child_count);
                    check_field("empty_min_max", due.empty, result.empty_min_max);
                    check_field("count_overflow", due.saturated, result.count_overflow);
                end
            end
            outstanding = aggregates_due.size();
        end
    end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the grouped score aggregator with directed groups and random
// groups under every mode setting, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import gsa_pkg::*;

    localparam mode_t MODE_SPARE_6 = 3'd6;
    localparam mode_t MODE_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS  = 850;
    localparam int PHASE_ITEMS   = 70;
    localparam int QUIET_TAIL    = 120;
    localparam int SETTLE_CYCLES = 64;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   scores_sent;
    int   mismatches;
    int   outstanding;

    gsa_item_if   item_ch();
    gsa_result_if result_ch();
    gsa_cfg_if    cfg_ch();

    grouped_score_aggregator_top uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (result_ch),
        .cfg        (cfg_ch)
    );

    gsa_aggregate_monitor agg_mon
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result receiver with random stall bursts
    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    function automatic logic signed [SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 7))
            0: return SCORE_MAX;
            1: return SCORE_MIN;
            2: return '0;
            3: return SCORE_W'(int'($urandom_range(0, 131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    // one item, with an optional idle burst before it
    task automatic send_item(input logic signed [SCORE_W-1:0] parent,
                             input logic signed [SCORE_W-1:0] child,
                             input logic has_child, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.parent_score <= parent;
        item_ch.child_score  <= child;
        item_ch.has_child    <= has_child;
        item_ch.last         <= last;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // stop sending and wait until every aggregate has come back
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input mode_t mode);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= mode;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly short groups, some longer, with dropped items mixed in
    task automatic send_random_group();
        int n_children;
        n_children = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                 : $urandom_range(0, 6);
        for (int i = 0; i < n_children; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                send_item(pick_score(), pick_score(), 1'b0, 1'b0);
                scores_sent++;
            end
            send_item(pick_score(), pick_score(), 1'b1, 1'b0);
            scores_sent++;
        end
        send_item(pick_score(), pick_score(), 1'($urandom_range(0, 1)), 1'b1);
        scores_sent++;
    endtask

    // stimulus and verdict
    initial
    begin
        int phase;
        int target;
        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.parent_score <= '0;
        item_ch.child_score  <= '0;
        item_ch.has_child    <= 1'b0;
        item_ch.last         <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.data          <= MODE_PARENT;
        idle_on     = 1'b1;
        scores_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // parent score mode straight out of reset
        send_item(SCORE_MIN, SCORE_MAX, 1'b1, 1'b0);
        send_item(SCORE_MIN, '0, 1'b0, 1'b1);
        send_item(SCORE_MAX, SCORE_MIN, 1'b1, 1'b1);

        // min: empty group, then extremes
        set_mode(MODE_MIN);
        send_item('0, '0, 1'b0, 1'b1);
        send_item('0, SCORE_MAX, 1'b1, 1'b0);
        send_item('0, SCORE_MIN, 1'b1, 1'b0);
        send_item('0, 32'sd5, 1'b1, 1'b1);

        // max: empty group, then all-minimum children with a dropped item
        set_mode(MODE_MAX);
        send_item('0, '0, 1'b0, 1'b1);
        send_item('0, SCORE_MIN, 1'b1, 1'b0);
        send_item('0, SCORE_MIN, 1'b0, 1'b0);
        send_item('0, SCORE_MIN, 1'b1, 1'b1);

        // count
        set_mode(MODE_COUNT);
        send_item('0, '0, 1'b0, 1'b1);
        send_item('0, SCORE_MAX, 1'b1, 1'b0);
        send_item('0, SCORE_MIN, 1'b1, 1'b0);
        send_item('0, '0, 1'b1, 1'b1);

        // average: empty group, and negative sums truncated toward zero
        set_mode(MODE_AVG);
        send_item('0, '0, 1'b0, 1'b1);
        send_item('0, -32'sd3, 1'b1, 1'b0);
        send_item('0, 32'sd2, 1'b1, 1'b1);
        send_item('0, -32'sd7, 1'b1, 1'b0);
        send_item('0, 32'sd2, 1'b1, 1'b1);

        // sum
        set_mode(MODE_SUM);
        send_item('0, SCORE_MAX, 1'b1, 1'b0);
        send_item('0, SCORE_MAX, 1'b1, 1'b0);
        send_item('0, SCORE_MIN, 1'b1, 1'b1);

        // unused modes give the parent score
        set_mode(MODE_SPARE_6);
        send_item(SCORE_MAX, 32'sd1, 1'b1, 1'b1);
        set_mode(MODE_SPARE_7);
        send_item(SCORE_MIN, '0, 1'b0, 1'b1);

        // random groups, every mode once in order, then random modes
        phase = 0;
        while (scores_sent < RANDOM_ITEMS)
        begin
            if (phase < 2**MODE_W)
                set_mode(mode_t'(phase));
            else
                set_mode(mode_t'($urandom_range(0, 2**MODE_W - 1)));
            if (scores_sent >= RANDOM_ITEMS - QUIET_TAIL)
                idle_on = 1'b0;
            target = scores_sent + PHASE_ITEMS;
            while (scores_sent < target)
                send_random_group();
            phase++;
        end

        wait_drained();
        @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
